/* design/dwtv_pkg.sv */
// ============================================================================
// dwtv_pkg: shared types and constants for the DELEG wire validator
// Phase and verdict codes, key code set, register indexes and reset values.
// ============================================================================
package dwtv_pkg;

    localparam int BYTE_W     = 8;
    localparam int KEY_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_REQ    = 4;

    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [NUM_REQ-1:0] req_t;

    typedef enum logic [2:0] {
        PH_KEY_HI,
        PH_KEY_LO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_VALUE
    } phase_t;

    typedef enum logic [1:0] {
        VERDICT_OK      = 2'd0,
        VERDICT_FORMERR = 2'd1,
        VERDICT_END     = 2'd2
    } verdict_t;

    typedef struct packed {
        key_t mandatory;
        key_t ipv4;
        key_t ipv6;
        key_t server_name;
        key_t incl;
    } key_codes_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MANDATORY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_IPV4        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_IPV6        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SERVER_NAME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_INCL        = 3'd4;

    localparam key_t MANDATORY_KEY_RESET   = 16'd0;
    localparam key_t IPV4_KEY_RESET        = 16'd1;
    localparam key_t IPV6_KEY_RESET        = 16'd2;
    localparam key_t SERVER_NAME_KEY_RESET = 16'd3;
    localparam key_t INCL_KEY_RESET        = 16'd4;

    // bit positions in the required-key flags
    localparam int REQ_IPV4 = 0;
    localparam int REQ_IPV6 = 1;
    localparam int REQ_NAME = 2;
    localparam int REQ_INCL = 3;

endpackage

/* design/dwtv_if.sv */
// ============================================================================
// dwtv_if: channel interfaces for the DELEG wire validator
// Record byte channel, verdict channel and configuration write channel.
// ============================================================================
interface dwtv_byte_if;
    logic                       valid;
    logic                       ready;
    logic [dwtv_pkg::BYTE_W-1:0] data_byte;
    logic                       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface dwtv_verdict_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, verdict, input ready);
    modport sink   (input valid, verdict, output ready);
endinterface

interface dwtv_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dwtv_pkg::CFG_IDX_W-1:0]  index;
    logic [dwtv_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/deleg_wire_tlv_validator.sv */
// ============================================================================
// deleg_wire_tlv_validator: DELEG record wire format validator
// Checks key order, value lengths and mandatory keys; one verdict per record.
// ============================================================================
// The block takes one record byte per transfer on the record channel and
// sustains one byte per clock. Each byte is held in an input register, then
// a single step of parse logic updates the record state; on the byte marked
// last the verdict (0 valid, 1 format error, 2 unexpected end) is loaded
// into the result register, which offers it on the result channel. Only a
// last byte can wait in the input register, and only while an earlier
// verdict is still not taken; other bytes never stall. Key codes for the
// mandatory list, IPv4, IPv6, server name and include parameters sit in
// five registers written through the cfg channel (index 0 to 4, other
// indexes ignored); write them only while no record is in flight. No
// clearing pass after reset.
module deleg_wire_tlv_validator (
    input  logic          clk,
    input  logic          rst_n,
    dwtv_byte_if.sink     record,
    dwtv_verdict_if.source result,
    dwtv_cfg_if.sink      cfg
);
    import dwtv_pkg::*;

    // input register
    logic              in_v_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // result register
    logic              out_v_reg;
    verdict_t          verdict_reg;

    key_codes_t        codes;
    verdict_t          verdict;
    logic              advance;

    dwtv_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .codes (codes)
    );

    // a last byte may leave only if the result register is free or its verdict is taken
    assign advance = in_v_reg && (!in_last_reg || !out_v_reg || result.ready);

    dwtv_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .codes     (codes),
        .verdict   (verdict)
    );

    assign record.ready  = !in_v_reg || advance;
    assign result.valid  = out_v_reg;
    assign result.verdict = verdict_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (record.ready)
        begin
            in_v_reg <= record.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (record.valid && record.ready)
        begin
            in_byte_reg <= record.data_byte;
            in_last_reg <= record.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_v_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            verdict_reg <= verdict;
        end
    end

`ifndef SYNTHESIS
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_v_reg) |-> $past(advance && in_last_reg))
        else $error("verdict raised without a last byte");

    a_inner_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_v_reg && !in_last_reg) |-> advance)
        else $error("non-last byte stalled in input register");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_v_reg && !advance) |=> in_v_reg && $stable(in_byte_reg) && $stable(in_last_reg))
        else $error("stalled input byte lost");
`endif

endmodule

/* design/dwtv_cfg_regs.sv */
// ============================================================================
// dwtv_cfg_regs: key code registers
// Holds the five key codes; writes are taken on every cycle.
// ============================================================================
module dwtv_cfg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    dwtv_cfg_if.sink             cfg,
    output dwtv_pkg::key_codes_t codes
);
    import dwtv_pkg::*;

    key_codes_t codes_reg;

    assign cfg.ready = 1'b1;
    assign codes     = codes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.mandatory   <= MANDATORY_KEY_RESET;
            codes_reg.ipv4        <= IPV4_KEY_RESET;
            codes_reg.ipv6        <= IPV6_KEY_RESET;
            codes_reg.server_name <= SERVER_NAME_KEY_RESET;
            codes_reg.incl        <= INCL_KEY_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_IDX_MANDATORY:   codes_reg.mandatory   <= cfg.data;
                CFG_IDX_IPV4:        codes_reg.ipv4        <= cfg.data;
                CFG_IDX_IPV6:        codes_reg.ipv6        <= cfg.data;
                CFG_IDX_SERVER_NAME: codes_reg.server_name <= cfg.data;
                CFG_IDX_INCL:        codes_reg.incl        <= cfg.data;
                default:             ;
            endcase
        end
    end

endmodule

/* design/dwtv_parser.sv */
// ============================================================================
// dwtv_parser: record parse state and per-byte checks
// Walks key/length/value fields one byte per step and computes the verdict.
// ============================================================================
module dwtv_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [dwtv_pkg::BYTE_W-1:0] data_byte,
    input  logic                      last_byte,
    input  dwtv_pkg::key_codes_t      codes,
    output dwtv_pkg::verdict_t        verdict
);
    import dwtv_pkg::*;

    phase_t            phase_reg,      phase_next;
    logic [BYTE_W-1:0] hold_reg,       hold_next;
    key_t              cur_key_reg,    cur_key_next;
    key_t              prev_key_reg,   prev_key_next;
    logic              first_reg,      first_next;
    key_t              len_reg,        len_next;
    key_t              left_reg,       left_next;
    key_t              list_prev_reg,  list_prev_next;
    logic              list_first_reg, list_first_next;
    logic              pend_reg,       pend_next;
    req_t              req_reg,        req_next;
    logic              err_reg,        err_next;

    always_comb
    begin
        key_t     key_v;
        logic     finish;
        logic     bad;
        req_t     clr;

        phase_next      = phase_reg;
        hold_next       = hold_reg;
        cur_key_next    = cur_key_reg;
        prev_key_next   = prev_key_reg;
        first_next      = first_reg;
        len_next        = len_reg;
        left_next       = left_reg;
        list_prev_next  = list_prev_reg;
        list_first_next = list_first_reg;
        pend_next       = pend_reg;
        req_next        = req_reg;
        err_next        = err_reg;
        key_v           = {hold_reg, data_byte};
        finish          = 1'b0;
        bad             = 1'b0;
        clr             = '0;

        // after an error, bytes are ignored until the end of the record
        if (!err_reg)
        begin
            case (phase_reg)
                PH_KEY_HI:
                begin
                    hold_next  = data_byte;
                    phase_next = PH_KEY_LO;
                end
                PH_KEY_LO:
                begin
                    cur_key_next = key_v;
                    if (!first_reg && (key_v <= prev_key_reg))
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        first_next    = 1'b0;
                        prev_key_next = key_v;
                        phase_next    = PH_LEN_HI;
                    end
                end
                PH_LEN_HI:
                begin
                    hold_next  = data_byte;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next        = key_v;
                    left_next       = key_v;
                    pend_next       = 1'b0;
                    list_first_next = 1'b1;
                    list_prev_next  = '0;
                    if (key_v == '0)
                        finish = 1'b1;
                    else
                        phase_next = PH_VALUE;
                end
                PH_VALUE:
                begin
                    // mandatory list: even offset holds the high byte
                    if (cur_key_reg == codes.mandatory)
                    begin
                        if ((len_reg[0] ^ left_reg[0]) == 1'b0)
                        begin
                            hold_next = data_byte;
                        end
                        else
                        begin
                            if (!list_first_reg && (list_prev_reg >= key_v))
                                pend_next = 1'b1;
                            list_first_next = 1'b0;
                            if (key_v == codes.ipv4)        req_next[REQ_IPV4] = 1'b1;
                            if (key_v == codes.ipv6)        req_next[REQ_IPV6] = 1'b1;
                            if (key_v == codes.server_name) req_next[REQ_NAME] = 1'b1;
                            if (key_v == codes.incl)        req_next[REQ_INCL] = 1'b1;
                            list_prev_next = key_v;
                        end
                    end
                    left_next = left_reg - key_t'(1);
                    if (left_reg == key_t'(1))
                        finish = 1'b1;
                end
                default:
                begin
                    phase_next = PH_KEY_HI;
                end
            endcase
        end

        // value complete: length checks by key kind
        if (finish)
        begin
            bad = pend_next;
            if (cur_key_next == codes.mandatory)
            begin
                if (len_next[0] || (len_next == '0))
                    bad = 1'b1;
            end
            if (cur_key_next == codes.ipv4)
            begin
                if ((len_next[1:0] != 2'd0) || (len_next == '0))
                    bad = 1'b1;
                clr[REQ_IPV4] = 1'b1;
            end
            if (cur_key_next == codes.ipv6)
            begin
                if ((len_next[3:0] != 4'd0) || (len_next == '0))
                    bad = 1'b1;
                clr[REQ_IPV6] = 1'b1;
            end
            if (cur_key_next == codes.server_name)
            begin
                if (len_next == '0)
                    bad = 1'b1;
                clr[REQ_NAME] = 1'b1;
            end
            if (cur_key_next == codes.incl)
            begin
                if (len_next == '0)
                    bad = 1'b1;
                clr[REQ_INCL] = 1'b1;
            end
            if (bad)
                err_next = 1'b1;
            else
                req_next = req_next & ~clr;
            phase_next = PH_KEY_HI;
        end

        if (err_next)
            verdict = VERDICT_FORMERR;
        else if (phase_next != PH_KEY_HI)
            verdict = VERDICT_END;
        else if (req_next != '0)
            verdict = VERDICT_FORMERR;
        else
            verdict = VERDICT_OK;

        // end of record: back to the start state
        if (last_byte)
        begin
            phase_next      = PH_KEY_HI;
            hold_next       = '0;
            cur_key_next    = '0;
            prev_key_next   = '0;
            first_next      = 1'b1;
            len_next        = '0;
            left_next       = '0;
            list_prev_next  = '0;
            list_first_next = 1'b1;
            pend_next       = 1'b0;
            req_next        = '0;
            err_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_KEY_HI;
            hold_reg       <= '0;
            cur_key_reg    <= '0;
            prev_key_reg   <= '0;
            first_reg      <= 1'b1;
            len_reg        <= '0;
            left_reg       <= '0;
            list_prev_reg  <= '0;
            list_first_reg <= 1'b1;
            pend_reg       <= 1'b0;
            req_reg        <= '0;
            err_reg        <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            hold_reg       <= hold_next;
            cur_key_reg    <= cur_key_next;
            prev_key_reg   <= prev_key_next;
            first_reg      <= first_next;
            len_reg        <= len_next;
            left_reg       <= left_next;
            list_prev_reg  <= list_prev_next;
            list_first_reg <= list_first_next;
            pend_reg       <= pend_next;
            req_reg        <= req_next;
            err_reg        <= err_next;
        end
    end

`ifndef SYNTHESIS
    a_record_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (step && last_byte) |=> (phase_reg == PH_KEY_HI) && (req_reg == '0) && !err_reg)
        else $error("parse state not cleared after record end");

    a_value_left: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_VALUE) |-> (left_reg != '0))
        else $error("value phase with no bytes left");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (step && err_reg && !last_byte) |=> err_reg)
        else $error("error dropped inside a record");
`endif

endmodule
